[src/ccbm_pkg.sv]
`default_nettype none

package ccbm_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  tick_cycles;
    } in_word_t;

    typedef struct packed {
        logic [1:0] target_kind;
        logic [7:0] bank_number;
        logic [1:0] mirroring_mode;
        logic       irq_line;
    } out_word_t;

    typedef struct packed {
        logic       we;
        logic       index;
        logic [0:0] data;
    } cfg_write_t;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_CPU_QUERY = 2'd1;
    localparam logic [1:0] OP_PPU_QUERY = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PRG  = 2'd1;
    localparam logic [1:0] KIND_WRAM = 2'd2;
    localparam logic [1:0] KIND_CHR  = 2'd3;

    localparam logic CFG_REGISTER_MODE    = 1'b0;
    localparam logic CFG_HEADER_MIRRORING = 1'b1;

    localparam logic [15:0] ADDR_MIRROR_LO   = 16'h42FE;
    localparam logic [15:0] ADDR_MIRROR_HI   = 16'h42FF;
    localparam logic [15:0] ADDR_IRQ_DISABLE = 16'h4501;
    localparam logic [15:0] ADDR_IRQ_LOW     = 16'h4502;
    localparam logic [15:0] ADDR_IRQ_HIGH    = 16'h4503;
    localparam logic [15:0] ADDR_PRG_LO      = 16'h4504;
    localparam logic [15:0] ADDR_PRG_HI      = 16'h4507;
    localparam logic [15:0] ADDR_CHR_LO      = 16'h4510;
    localparam logic [15:0] ADDR_CHR_HI      = 16'h4517;
    localparam logic [15:0] ADDR_WRAM_LO     = 16'h6000;
    localparam logic [15:0] ADDR_PPU_LIMIT   = 16'h2000;

    localparam logic [6:0] PRG_FIXED_16K   = 7'h07;
    localparam logic [7:0] PRG_LAST_RESET  = 8'hFF;
    localparam logic [1:0] MIRROR_RESET    = 2'b11;

endpackage

`default_nettype wire

[src/copier_cart_bank_mapper_irq_core.sv]
`default_nettype none

// channel  direction  handshake           payload
// s_       in         s_valid / s_ready   s_word (ccbm_pkg::in_word_t)
// m_       out        m_valid / m_ready   m_word (ccbm_pkg::out_word_t)
// cfg_     in         cfg_we              cfg_index, cfg_data
// One word per cycle sustained while no result stalls; a word passes the input
// register, then the result register. The mapper state and the result are computed
// in one pass from the input register and land on the same edge, but a config
// write on that edge wins and the state is not updated. Synchronous active-low
// reset restores all mapper state; config writes apply at once. A stalled result
// holds the input register; s_ready drops only when both are full.

module copier_cart_bank_mapper_irq_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [0:0]          cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ccbm_pkg::in_word_t  s_word,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ccbm_pkg::out_word_t      m_word
);

    logic                 in_valid_reg;
    ccbm_pkg::in_word_t   in_word_reg;
    logic                 out_valid_reg;
    ccbm_pkg::out_word_t  out_word_reg;
    ccbm_pkg::out_word_t  result;
    ccbm_pkg::cfg_write_t cfg;
    logic                 advance;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    ccbm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_word_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_word_reg <= result;
        end
    end

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while pipeline can move");

    a_write_gives_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_word_reg.op == ccbm_pkg::OP_WRITE)
            |=> (m_valid && m_word.target_kind == ccbm_pkg::KIND_NONE))
        else $error("write word produced a mapping");
`endif

endmodule

`default_nettype wire

[src/ccbm_core.sv]
`default_nettype none

module ccbm_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ccbm_pkg::cfg_write_t cfg,
    input  wire logic                 advance,
    input  wire ccbm_pkg::in_word_t   item,
    output ccbm_pkg::out_word_t       result
);

    logic        register_mode_reg;
    logic [7:0]  prg_bank_reg [4];
    logic [7:0]  prg_bank_next [4];
    logic [7:0]  chr_bank_reg [8];
    logic [7:0]  chr_bank_next [8];
    logic [7:0]  latch_reg;
    logic [7:0]  latch_next;
    logic [1:0]  mirror_reg;
    logic [1:0]  mirror_next;
    logic        enable_reg;
    logic        enable_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        irq_reg;
    logic        irq_next;
    logic [16:0] tick_sum;
    logic [1:0]  kind;
    logic [7:0]  bank;

    assign tick_sum = {1'b0, count_reg} + {9'd0, item.tick_cycles};

    always_comb begin
        prg_bank_next = prg_bank_reg;
        chr_bank_next = chr_bank_reg;
        latch_next    = latch_reg;
        mirror_next   = mirror_reg;
        enable_next   = enable_reg;
        count_next    = count_reg;
        irq_next      = irq_reg;
        kind          = ccbm_pkg::KIND_NONE;
        bank          = 8'd0;
        unique case (item.op)
            ccbm_pkg::OP_WRITE: begin
                priority if (item.addr == ccbm_pkg::ADDR_MIRROR_LO ||
                             item.addr == ccbm_pkg::ADDR_MIRROR_HI) begin
                    mirror_next = {item.addr[0], item.data[4]};
                end else if (item.addr == ccbm_pkg::ADDR_IRQ_DISABLE) begin
                    enable_next = 1'b0;
                    irq_next    = 1'b0;
                end else if (item.addr == ccbm_pkg::ADDR_IRQ_LOW) begin
                    count_next = {count_reg[15:8], item.data};
                    irq_next   = 1'b0;
                end else if (item.addr == ccbm_pkg::ADDR_IRQ_HIGH) begin
                    count_next  = {item.data, count_reg[7:0]};
                    enable_next = 1'b1;
                    irq_next    = 1'b0;
                end else if (item.addr >= ccbm_pkg::ADDR_PRG_LO &&
                             item.addr <= ccbm_pkg::ADDR_PRG_HI) begin
                    prg_bank_next[item.addr[1:0]] = item.data;
                end else if (item.addr >= ccbm_pkg::ADDR_CHR_LO &&
                             item.addr <= ccbm_pkg::ADDR_CHR_HI) begin
                    chr_bank_next[item.addr[2:0]] = item.data;
                end else if (item.addr[15]) begin
                    latch_next = item.data;
                end
            end
            ccbm_pkg::OP_CPU_QUERY: begin
                if (item.addr[15]) begin
                    kind = ccbm_pkg::KIND_PRG;
                    priority if (register_mode_reg) begin
                        bank = prg_bank_reg[item.addr[14:13]];
                    end else if (!item.addr[14]) begin
                        bank = {1'b0, latch_reg[7:2], item.addr[13]};
                    end else begin
                        bank = {ccbm_pkg::PRG_FIXED_16K, item.addr[13]};
                    end
                end else if (item.addr >= ccbm_pkg::ADDR_WRAM_LO) begin
                    kind = ccbm_pkg::KIND_WRAM;
                end
            end
            ccbm_pkg::OP_PPU_QUERY: begin
                if (item.addr < ccbm_pkg::ADDR_PPU_LIMIT) begin
                    kind = ccbm_pkg::KIND_CHR;
                    if (register_mode_reg) begin
                        bank = chr_bank_reg[item.addr[12:10]];
                    end else begin
                        bank = {3'd0, latch_reg[1:0], item.addr[12:10]};
                    end
                end
            end
            ccbm_pkg::OP_TICK: begin
                if (enable_reg) begin
                    if (tick_sum[16]) begin
                        irq_next    = 1'b1;
                        enable_next = 1'b0;
                        count_next  = 16'd0;
                    end else begin
                        count_next = tick_sum[15:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign result.target_kind    = kind;
    assign result.bank_number    = bank;
    assign result.mirroring_mode = mirror_next;
    assign result.irq_line       = irq_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            register_mode_reg <= 1'b0;
            prg_bank_reg      <= '{8'd0, 8'd0, 8'd0, ccbm_pkg::PRG_LAST_RESET};
            chr_bank_reg      <= '{default: 8'd0};
            latch_reg         <= 8'd0;
            mirror_reg        <= ccbm_pkg::MIRROR_RESET;
            enable_reg        <= 1'b0;
            count_reg         <= 16'd0;
            irq_reg           <= 1'b0;
        end else if (cfg.we) begin
            if (cfg.index == ccbm_pkg::CFG_REGISTER_MODE) begin
                register_mode_reg <= cfg.data[0];
            end else begin
                mirror_reg <= {1'b1, ~cfg.data[0]};
            end
        end else if (advance) begin
            prg_bank_reg <= prg_bank_next;
            chr_bank_reg <= chr_bank_next;
            latch_reg    <= latch_next;
            mirror_reg   <= mirror_next;
            enable_reg   <= enable_next;
            count_reg    <= count_next;
            irq_reg      <= irq_next;
        end
    end

`ifndef SYNTH
    a_irq_excludes_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(enable_reg && irq_reg))
        else $error("irq pending while counter enabled");

    a_irq_rises_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(irq_reg) |-> $past(advance && item.op == ccbm_pkg::OP_TICK && !cfg.we))
        else $error("irq raised without a tick");
`endif

endmodule

`default_nettype wire
